@@ rtl/bsc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bsc_pkg
// Shared types, constants and helpers for the barometric compensation block.
// ============================================================================
package bsc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_DIV,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_P6,
        ST_P7,
        ST_P8,
        ST_P9,
        ST_P10,
        ST_P11,
        ST_OUT
    } state_t;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] POLY_SQ     = 32'd3038;
    localparam logic [31:0] POLY_LIN    = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] POLY_OFFSET = 32'd3791;
    localparam logic [31:0] PRESS_SCALE = 32'd50000;
    localparam logic [31:0] KELVIN_OFS  = 32'd2732;
    localparam logic [31:0] AC4_BIAS    = 32'd32768;

    localparam logic [4:0] DIV_LAST = 5'd31;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

@@ rtl/barometric_sensor_compensation.sv @@
`timescale 1ns / 1ps
// ============================================================================
// barometric_sensor_compensation
// Integer compensation of raw barometric temperature and pressure readings.
// ============================================================================
// A zero divisor ends the item early. One item at a time: a new request is
// taken only in the idle state, after the last result is loaded into the
// output register; the pace is set by the 32-step shared divider and the
// shared 32-bit multiplier stepped by the sequencer. Reset (rst_n, async low)
// clears all coefficients, the stored B5 term and the control state.
module barometric_sensor_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] raw_reading
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] value, [31] zero
    output logic        m_tuser,   // [0] fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    bsc_pkg::state_t state_reg, state_next;

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg, b5_next;
    logic [23:0] raw_reg, raw_next;
    logic        cmd_reg, cmd_next;
    logic [31:0] t1_reg, t1_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        dbl_reg, dbl_next;
    logic [30:0] res_reg, res_next;
    logic        flt_reg, flt_next;
    logic        ovld_reg, ovld_next;
    logic [30:0] oval_reg, oval_next;
    logic        oflt_reg, oflt_next;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [32:0] rem_sh, rem_diff;
    logic [31:0] x1, dv, num, x2, b5n, tk, x3, sum1, sum2, up, q, pf;

    assign mul_p     = mul_a * mul_b;
    assign rem_sh    = {rem_reg, quo_reg[31]};
    assign rem_diff  = rem_sh - {1'b0, dvs_reg};
    assign s_tready  = (state_reg == bsc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovld_reg;
    assign m_tdata   = {1'b0, oval_reg};
    assign m_tuser   = oflt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsc_pkg::ST_IDLE;
            ac12_reg  <= '0;
            ac34_reg  <= '0;
            ac56_reg  <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= '0;
            b5_reg    <= '0;
            ovld_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            b5_reg    <= b5_next;
            ovld_reg  <= ovld_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bsc_pkg::REG_AC1_AC2: ac12_reg <= cfg_data;
                    bsc_pkg::REG_AC3_AC4: ac34_reg <= cfg_data;
                    bsc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                    bsc_pkg::REG_B1_B2:   b12_reg  <= cfg_data;
                    bsc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                    bsc_pkg::REG_OSS:     oss_reg  <= cfg_data[1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        cmd_reg  <= cmd_next;
        t1_reg   <= t1_next;
        acc_reg  <= acc_next;
        b6_reg   <= b6_next;
        sq_reg   <= sq_next;
        b3_reg   <= b3_next;
        b4_reg   <= b4_next;
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        dbl_reg  <= dbl_next;
        res_reg  <= res_next;
        flt_reg  <= flt_next;
        oval_reg <= oval_next;
        oflt_reg <= oflt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        b5_next    = b5_reg;
        raw_next   = raw_reg;
        cmd_next   = cmd_reg;
        t1_next    = t1_reg;
        acc_next   = acc_reg;
        b6_next    = b6_reg;
        sq_next    = sq_reg;
        b3_next    = b3_reg;
        b4_next    = b4_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        dbl_next   = dbl_reg;
        res_next   = res_reg;
        flt_next   = flt_reg;
        ovld_next  = ovld_reg && !m_tready;
        oval_next  = oval_reg;
        oflt_next  = oflt_reg;
        mul_a      = '0;
        mul_b      = '0;
        x1         = '0;
        dv         = '0;
        num        = '0;
        x2         = '0;
        b5n        = '0;
        tk         = '0;
        x3         = '0;
        sum1       = '0;
        sum2       = '0;
        up         = '0;
        q          = '0;
        pf         = '0;

        case (state_reg)
            bsc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    raw_next   = s_tdata;
                    cmd_next   = s_tuser;
                    state_next = (s_tuser == bsc_pkg::CMD_PRESS) ? bsc_pkg::ST_P0
                                                                 : bsc_pkg::ST_T0;
                end
            end
            bsc_pkg::ST_T0:
            begin
                mul_a      = {16'd0, raw_reg[15:0]} - {16'd0, ac56_reg[15:0]};
                mul_b      = {16'd0, ac56_reg[31:16]};
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_T1;
            end
            bsc_pkg::ST_T1:
            begin
                x1       = bsc_pkg::asr(t1_reg, 5'd15);
                dv       = x1 + bsc_pkg::sx16(mcmd_reg[15:0]);
                num      = bsc_pkg::sx16(mcmd_reg[31:16]) << 11;
                acc_next = x1;
                if (dv == '0)
                begin
                    res_next   = bsc_pkg::KELVIN_OFS[30:0];
                    flt_next   = 1'b1;
                    state_next = bsc_pkg::ST_OUT;
                end
                else
                begin
                    neg_next   = num[31] ^ dv[31];
                    quo_next   = num[31] ? (32'd0 - num) : num;
                    dvs_next   = dv[31] ? (32'd0 - dv) : dv;
                    rem_next   = '0;
                    cnt_next   = bsc_pkg::DIV_LAST;
                    state_next = bsc_pkg::ST_DIV;
                end
            end
            bsc_pkg::ST_DIV:
            begin
                if (!rem_diff[32])
                begin
                    rem_next = rem_diff[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = (cmd_reg == bsc_pkg::CMD_PRESS) ? bsc_pkg::ST_P8
                                                                 : bsc_pkg::ST_T2;
                end
            end
            bsc_pkg::ST_T2:
            begin
                x2         = neg_reg ? (32'd0 - quo_reg) : quo_reg;
                b5n        = acc_reg + x2;
                b5_next    = b5n;
                tk         = bsc_pkg::asr(b5n + 32'd8, 5'd4) + bsc_pkg::KELVIN_OFS;
                res_next   = {15'd0, tk[15:0]};
                flt_next   = 1'b0;
                state_next = bsc_pkg::ST_OUT;
            end
            bsc_pkg::ST_P0:
            begin
                b6_next    = b5_reg - bsc_pkg::B6_OFFSET;
                mul_a      = b6_next;
                mul_b      = b6_next;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P1;
            end
            bsc_pkg::ST_P1:
            begin
                sq_next    = bsc_pkg::asr(t1_reg, 5'd12);
                mul_a      = bsc_pkg::sx16(b12_reg[15:0]);
                mul_b      = sq_next;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P2;
            end
            bsc_pkg::ST_P2:
            begin
                acc_next   = bsc_pkg::asr(t1_reg, 5'd11);
                mul_a      = bsc_pkg::sx16(ac12_reg[15:0]);
                mul_b      = b6_reg;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P3;
            end
            bsc_pkg::ST_P3:
            begin
                x3         = acc_reg + bsc_pkg::asr(t1_reg, 5'd11);
                sum1       = (bsc_pkg::sx16(ac12_reg[31:16]) << 2) + x3;
                sum2       = (sum1 << oss_reg) + 32'd2;
                b3_next    = bsc_pkg::asr(sum2, 5'd2);
                mul_a      = bsc_pkg::sx16(ac34_reg[31:16]);
                mul_b      = b6_reg;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P4;
            end
            bsc_pkg::ST_P4:
            begin
                acc_next   = bsc_pkg::asr(t1_reg, 5'd13);
                mul_a      = bsc_pkg::sx16(b12_reg[31:16]);
                mul_b      = sq_reg;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P5;
            end
            bsc_pkg::ST_P5:
            begin
                x3 = bsc_pkg::asr(acc_reg + bsc_pkg::asr(t1_reg, 5'd16) + 32'd2, 5'd2);
                mul_a      = {16'd0, ac34_reg[15:0]};
                mul_b      = x3 + bsc_pkg::AC4_BIAS;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P6;
            end
            bsc_pkg::ST_P6:
            begin
                b4_next = t1_reg >> 15;
                if (b4_next == '0)
                begin
                    res_next   = '0;
                    flt_next   = 1'b1;
                    state_next = bsc_pkg::ST_OUT;
                end
                else
                begin
                    up         = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});
                    mul_a      = up - b3_reg;
                    mul_b      = bsc_pkg::PRESS_SCALE >> oss_reg;
                    t1_next    = mul_p;
                    state_next = bsc_pkg::ST_P7;
                end
            end
            bsc_pkg::ST_P7:
            begin
                dbl_next   = !t1_reg[31];
                quo_next   = t1_reg[31] ? t1_reg : (t1_reg << 1);
                dvs_next   = b4_reg;
                neg_next   = 1'b0;
                rem_next   = '0;
                cnt_next   = bsc_pkg::DIV_LAST;
                state_next = bsc_pkg::ST_DIV;
            end
            bsc_pkg::ST_P8:
            begin
                p_next     = dbl_reg ? quo_reg : (quo_reg << 1);
                q          = bsc_pkg::asr(p_next, 5'd8);
                mul_a      = q;
                mul_b      = q;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P9;
            end
            bsc_pkg::ST_P9:
            begin
                mul_a      = t1_reg;
                mul_b      = bsc_pkg::POLY_SQ;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P10;
            end
            bsc_pkg::ST_P10:
            begin
                acc_next   = bsc_pkg::asr(t1_reg, 5'd16);
                mul_a      = bsc_pkg::POLY_LIN;
                mul_b      = p_reg;
                t1_next    = mul_p;
                state_next = bsc_pkg::ST_P11;
            end
            bsc_pkg::ST_P11:
            begin
                sum1       = acc_reg + bsc_pkg::asr(t1_reg, 5'd16) + bsc_pkg::POLY_OFFSET;
                pf         = p_reg + bsc_pkg::asr(sum1, 5'd4);
                res_next   = (pf != '0 && !pf[31]) ? pf[30:0] : 31'd0;
                flt_next   = 1'b0;
                state_next = bsc_pkg::ST_OUT;
            end
            bsc_pkg::ST_OUT:
            begin
                if (!ovld_reg || m_tready)
                begin
                    ovld_next  = 1'b1;
                    oval_next  = res_reg;
                    oflt_next  = flt_reg;
                    state_next = bsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
